>>> hw/rtl/balloc_pkg.sv
// Shared types, constants and helper functions for the buddy allocator.
`timescale 1ns / 1ps
`default_nettype none

package balloc_pkg;

	// Heap geometry
	localparam int HEAP_ORDER = 14;
	localparam int LOG2_UNIT  = 5;
	localparam int UNIT_W     = HEAP_ORDER - LOG2_UNIT;
	localparam int UNITS      = 1 << UNIT_W;
	localparam int LINK_W     = UNIT_W + 1;
	localparam int NORDERS    = UNIT_W + 1;
	localparam int ORD_W      = 4;
	localparam int HEAP_BYTES = 1 << HEAP_ORDER;
	localparam int HDR_BYTES  = 8;

	// Field and port widths
	localparam int HEAP_W     = 15;
	localparam int SIZE_W     = 16;
	localparam int ADDR_W     = 14;
	localparam int USED_W     = 15;
	localparam int STAT_W     = 2;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 48;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [HEAP_W-1:0] HEAP_RESET = 15'd16384;
	localparam logic [APB_ADDR_W-3:0] REG_HEAP_BYTES = 1'b0;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef logic [LINK_W-1:0] link_t;
	typedef logic [UNIT_W-1:0] unit_t;
	typedef logic [ORD_W-1:0]  ord_t;

	localparam link_t NOLINK = LINK_W'(UNITS);

	// Per-unit bookkeeping word: free block start, allocated mark, order above minimum
	typedef struct packed {
		logic fs;
		logic am;
		ord_t k;
	} meta_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_FAIL = 2'd1,
		ST_IGN  = 2'd2
	} res_status_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DISP,
		S_SCAN,
		S_ARD,
		S_AUNL,
		S_SPLIT,
		S_PUSHB,
		S_AFIN,
		S_FRD,
		S_FCHK,
		S_FLOOP,
		S_FBCHK,
		S_PUSHA,
		S_OUT_OK,
		S_OUT_FAIL,
		S_OUT_IGN
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ACCEPT,
		OP_SCAN,
		OP_ARD,
		OP_UNLINK,
		OP_SPLIT,
		OP_PUSHA,
		OP_PUSHB,
		OP_AFIN,
		OP_FRD,
		OP_FCLR,
		OP_BRD,
		OP_MERGE,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t      op;
		res_status_t status;
	} dp_cmd_t;

	typedef struct packed {
		logic cfg_wr;
		logic clr_last;
		logic is_free;
		logic req_bad;
		logic head_empty;
		logic k_at_top;
		logic k_at_need;
		logic am_set;
		logic buddy_free;
		logic out_free;
	} dp_stat_t;

	// Effective heap size: capped at the top block, zero when too small to use
	function automatic logic [HEAP_W-1:0] eff_of(input logic [HEAP_W-1:0] heap);
		logic [HEAP_W-1:0] e;
		e = (heap > HEAP_W'(HEAP_BYTES)) ? HEAP_W'(HEAP_BYTES) : heap;
		if (e < HEAP_W'(1 << LOG2_UNIT))
			e = '0;
		return e;
	endfunction

	// Top order above the minimum: largest power of two within the effective size
	function automatic ord_t top_k_of(input logic [HEAP_W-1:0] heap);
		logic [HEAP_W-1:0] e;
		ord_t k;
		e = eff_of(heap);
		k = '0;
		for (int i = LOG2_UNIT + 1; i <= HEAP_ORDER; i++)
			if ((e >> i) != '0)
				k = ORD_W'(i - LOG2_UNIT);
		return k;
	endfunction

	// Order needed for a request plus its header
	function automatic logic [ORD_W:0] need_ord(input logic [SIZE_W-1:0] size);
		logic [SIZE_W:0] m;
		logic [ORD_W:0] o;
		m = {1'b0, size} + (SIZE_W+1)'(HDR_BYTES - 1);
		o = (ORD_W+1)'(LOG2_UNIT);
		for (int i = 0; i <= SIZE_W; i++)
			if (m[i] && ((ORD_W+1)'(i + 1) > o))
				o = (ORD_W+1)'(i + 1);
		return o;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/balloc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module balloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/balloc_ctrl.sv
// Sequencer for the buddy allocator: one state machine driving the datapath.
`timescale 1ns / 1ps
`default_nettype none

module balloc_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire balloc_pkg::dp_stat_t stat,
	output balloc_pkg::dp_cmd_t       cmd
);

	import balloc_pkg::*;

	ctrl_state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_nxt;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR:    if (stat.clr_last) state_nxt = S_IDLE;
			S_IDLE:     if (in_valid) state_nxt = S_DISP;
			S_DISP: begin
				if (stat.req_bad)
					state_nxt = stat.is_free ? S_OUT_IGN : S_OUT_FAIL;
				else
					state_nxt = stat.is_free ? S_FRD : S_SCAN;
			end
			S_SCAN: begin
				if (!stat.head_empty)
					state_nxt = S_ARD;
				else if (stat.k_at_top)
					state_nxt = S_OUT_FAIL;
			end
			S_ARD:      state_nxt = S_AUNL;
			S_AUNL:     state_nxt = S_SPLIT;
			S_SPLIT:    state_nxt = stat.k_at_need ? S_AFIN : S_PUSHB;
			S_PUSHB:    state_nxt = stat.is_free ? S_OUT_OK : S_SPLIT;
			S_AFIN:     state_nxt = S_OUT_OK;
			S_FRD:      state_nxt = S_FCHK;
			S_FCHK:     state_nxt = stat.am_set ? S_FLOOP : S_OUT_IGN;
			S_FLOOP:    state_nxt = stat.k_at_top ? S_PUSHA : S_FBCHK;
			S_FBCHK:    state_nxt = stat.buddy_free ? S_FLOOP : S_PUSHA;
			S_PUSHA:    state_nxt = S_PUSHB;
			S_OUT_OK, S_OUT_FAIL, S_OUT_IGN: begin
				if (stat.out_free)
					state_nxt = S_IDLE;
			end
			default:    state_nxt = S_CLEAR;
		endcase
		// A new heap size restarts the clearing sweep
		if (stat.cfg_wr)
			state_nxt = S_CLEAR;
	end

	// Datapath commands
	always_comb begin
		cmd.op     = OP_NONE;
		cmd.status = ST_OK;
		in_ready   = 1'b0;
		unique case (state_q)
			S_CLEAR: cmd.op = OP_CLEAR;
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					cmd.op = OP_ACCEPT;
			end
			S_DISP: cmd.op = OP_NONE;
			S_SCAN: begin
				if (stat.head_empty && !stat.k_at_top)
					cmd.op = OP_SCAN;
			end
			S_ARD:   cmd.op = OP_ARD;
			S_AUNL:  cmd.op = OP_UNLINK;
			S_SPLIT: begin
				if (!stat.k_at_need)
					cmd.op = OP_SPLIT;
			end
			S_PUSHB: cmd.op = OP_PUSHB;
			S_AFIN:  cmd.op = OP_AFIN;
			S_FRD:   cmd.op = OP_FRD;
			S_FCHK: begin
				if (stat.am_set)
					cmd.op = OP_FCLR;
			end
			S_FLOOP: begin
				if (!stat.k_at_top)
					cmd.op = OP_BRD;
			end
			S_FBCHK: begin
				if (stat.buddy_free)
					cmd.op = OP_MERGE;
			end
			S_PUSHA: cmd.op = OP_PUSHA;
			S_OUT_OK: begin
				cmd.status = ST_OK;
				if (stat.out_free)
					cmd.op = OP_OUT;
			end
			S_OUT_FAIL: begin
				cmd.status = ST_FAIL;
				if (stat.out_free)
					cmd.op = OP_OUT;
			end
			S_OUT_IGN: begin
				cmd.status = ST_IGN;
				if (stat.out_free)
					cmd.op = OP_OUT;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/balloc_dp.sv
// Datapath of the buddy allocator: free lists, link and bookkeeping stores, counters.
`timescale 1ns / 1ps
`default_nettype none

module balloc_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire balloc_pkg::dp_cmd_t                   cmd,
	output balloc_pkg::dp_stat_t                       stat,
	input  wire logic [balloc_pkg::IN_DATA_W-1:0]      s_tdata,
	input  wire logic                                  s_tuser,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic      [balloc_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic      [balloc_pkg::STAT_W-1:0]         m_tuser,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [balloc_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [balloc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [balloc_pkg::APB_DATA_W-1:0]     prdata
);

	import balloc_pkg::*;

	localparam int META_W = $bits(meta_t);

	// Configuration and derived heap geometry
	logic [HEAP_W-1:0] heap_q;
	logic [HEAP_W-1:0] eff;
	logic [HEAP_W-1:0] new_heap;
	ord_t              top_k;
	ord_t              new_top_k;
	logic              en;
	logic              new_en;
	logic              cfg_wr;

	// Control registers
	logic [UNIT_W-1:0] clr_cnt_q;
	link_t             head_q [NORDERS];
	logic [USED_W-1:0] used_q;
	logic              m_tvalid_q;

	// Per-item working registers
	logic              cmd_q;
	logic              bad_q;
	unit_t             u_q;
	unit_t             r_q;
	unit_t             pu_q;
	ord_t              k_q;
	ord_t              need_q;
	link_t             pn_q;
	logic [ADDR_W-1:0] m_addr_q;
	res_status_t       m_stat_q;
	logic [USED_W-1:0] m_used_q;
	logic [USED_W-1:0] m_free_q;

	// Memory ports
	logic              nx_we, pv_we, mt_we;
	unit_t             nx_waddr, pv_waddr, mt_waddr, raddr;
	link_t             nx_wdata, pv_wdata, nx_rd, pv_rd;
	meta_t             mt_wdata, mt_rd;
	logic [META_W-1:0] mt_rdata;

	// Helpers
	ord_t              hk;
	link_t             head_sel;
	unit_t             buddy;
	unit_t             split_unit;
	ord_t              split_k;
	logic [SIZE_W-1:0] in_size;
	logic [ADDR_W-1:0] in_addr;
	logic [ADDR_W-1:0] in_off;
	logic [ORD_W:0]    in_need;
	logic              alloc_bad;
	logic              free_bad;
	logic [USED_W-1:0] sz_afin;
	logic [USED_W-1:0] sz_free;
	logic [USED_W:0]   used_sum;
	logic              upd_head_unlink;

	assign eff       = eff_of(heap_q);
	assign en        = (eff != '0);
	assign top_k     = top_k_of(heap_q);
	assign new_heap  = pwdata[HEAP_W-1:0];
	assign new_en    = (eff_of(new_heap) != '0);
	assign new_top_k = top_k_of(new_heap);
	assign cfg_wr    = psel && penable && pwrite &&
	                   (paddr[APB_ADDR_W-1:2] == REG_HEAP_BYTES);

	assign prdata = (paddr[APB_ADDR_W-1:2] == REG_HEAP_BYTES) ?
	                APB_DATA_W'(heap_q) : '0;

	// Input decode
	assign in_size   = s_tdata[SIZE_W-1:0];
	assign in_addr   = s_tdata[SIZE_W+ADDR_W-1:SIZE_W];
	assign in_off    = in_addr - ADDR_W'(HDR_BYTES);
	assign in_need   = need_ord(in_size);
	assign alloc_bad = !en || (in_size == '0) ||
	                   (in_need > ({1'b0, top_k} + (ORD_W+1)'(LOG2_UNIT)));
	assign free_bad  = !en || (in_addr < ADDR_W'(HDR_BYTES)) ||
	                   (in_off[LOG2_UNIT-1:0] != '0) ||
	                   ((in_off[ADDR_W-1:LOG2_UNIT] >> top_k) != '0);

	// Free list head and buddy selection
	assign hk         = (cmd.op == OP_SPLIT) ? k_q - ORD_W'(1) : k_q;
	assign head_sel   = head_q[hk];
	assign split_k    = k_q - ORD_W'(1);
	assign split_unit = u_q | (unit_t'(1) << split_k);
	assign buddy      = u_q ^ (unit_t'(1) << k_q);

	assign sz_afin  = USED_W'(1) << (int'(k_q) + LOG2_UNIT);
	assign sz_free  = USED_W'(1) << (int'(mt_rd.k) + LOG2_UNIT);
	assign used_sum = {1'b0, used_q} + {1'b0, sz_afin};

	assign mt_rd = meta_t'(mt_rdata);

	// Shared read address for all three stores
	always_comb begin
		case (cmd.op)
			OP_ARD:  raddr = head_sel[UNIT_W-1:0];
			OP_BRD:  raddr = buddy;
			default: raddr = u_q;
		endcase
	end

	// Store writes for each command
	always_comb begin
		nx_we           = 1'b0;
		nx_waddr        = u_q;
		nx_wdata        = NOLINK;
		pv_we           = 1'b0;
		pv_waddr        = u_q;
		pv_wdata        = NOLINK;
		mt_we           = 1'b0;
		mt_waddr        = u_q;
		mt_wdata        = '{fs: 1'b0, am: 1'b0, k: k_q};
		upd_head_unlink = 1'b0;
		case (cmd.op)
			OP_CLEAR: begin
				nx_we    = 1'b1;
				nx_waddr = clr_cnt_q;
				pv_we    = 1'b1;
				pv_waddr = clr_cnt_q;
				mt_we    = 1'b1;
				mt_waddr = clr_cnt_q;
				mt_wdata = '{fs: (en && (clr_cnt_q == '0)), am: 1'b0, k: top_k};
			end
			OP_UNLINK, OP_MERGE: begin
				// Bridge the neighbours of the unit just read
				if (pv_rd != NOLINK) begin
					nx_we    = 1'b1;
					nx_waddr = pv_rd[UNIT_W-1:0];
					nx_wdata = nx_rd;
				end else begin
					upd_head_unlink = 1'b1;
				end
				if (nx_rd != NOLINK) begin
					pv_we    = 1'b1;
					pv_waddr = nx_rd[UNIT_W-1:0];
					pv_wdata = pv_rd;
				end
				mt_we    = 1'b1;
				mt_waddr = r_q;
				mt_wdata = '{fs: 1'b0, am: 1'b0, k: k_q};
			end
			OP_SPLIT: begin
				nx_we    = 1'b1;
				nx_waddr = split_unit;
				nx_wdata = head_sel;
				pv_we    = 1'b1;
				pv_waddr = split_unit;
				mt_we    = 1'b1;
				mt_waddr = split_unit;
				mt_wdata = '{fs: 1'b1, am: 1'b0, k: split_k};
			end
			OP_PUSHA: begin
				nx_we    = 1'b1;
				nx_waddr = u_q;
				nx_wdata = head_sel;
				pv_we    = 1'b1;
				pv_waddr = u_q;
				mt_we    = 1'b1;
				mt_waddr = u_q;
				mt_wdata = '{fs: 1'b1, am: 1'b0, k: k_q};
			end
			OP_PUSHB: begin
				if (pn_q != NOLINK) begin
					pv_we    = 1'b1;
					pv_waddr = pn_q[UNIT_W-1:0];
					pv_wdata = {1'b0, pu_q};
				end
			end
			OP_AFIN: begin
				mt_we    = 1'b1;
				mt_wdata = '{fs: 1'b0, am: 1'b1, k: k_q};
			end
			OP_FCLR: begin
				mt_we    = 1'b1;
				mt_wdata = '{fs: 1'b0, am: 1'b0, k: mt_rd.k};
			end
			default: ;
		endcase
	end

	// Control state: configuration, sweep counter, list heads, usage, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q     <= HEAP_RESET;
			clr_cnt_q  <= '0;
			used_q     <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < NORDERS; i++)
				head_q[i] <= (ORD_W'(i) == top_k_of(HEAP_RESET)) ? link_t'(0) : NOLINK;
		end else begin
			// Raise valid for a new result, drop it once taken
			if (cmd.op == OP_OUT)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			// Reinitialise the heap on a new size
			if (cfg_wr) begin
				heap_q    <= new_heap;
				clr_cnt_q <= '0;
				used_q    <= '0;
				for (int i = 0; i < NORDERS; i++)
					head_q[i] <= (new_en && (ORD_W'(i) == new_top_k)) ? link_t'(0) : NOLINK;
			end else begin
				case (cmd.op)
					OP_CLEAR: clr_cnt_q <= clr_cnt_q + UNIT_W'(1);
					OP_UNLINK, OP_MERGE: begin
						if (upd_head_unlink)
							head_q[k_q] <= nx_rd;
					end
					OP_SPLIT: head_q[split_k] <= {1'b0, split_unit};
					OP_PUSHA: head_q[k_q] <= {1'b0, u_q};
					OP_AFIN: begin
						used_q <= (used_sum > {1'b0, eff}) ? eff : used_sum[USED_W-1:0];
					end
					OP_FCLR: begin
						used_q <= (sz_free <= used_q) ? used_q - sz_free : '0;
					end
					default: ;
				endcase
			end
		end
	end

	// Working registers and output payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				cmd_q  <= s_tuser;
				bad_q  <= (s_tuser == CMD_FREE) ? free_bad : alloc_bad;
				u_q    <= in_off[ADDR_W-1:LOG2_UNIT];
				need_q <= ORD_W'(in_need - (ORD_W+1)'(LOG2_UNIT));
				k_q    <= ORD_W'(in_need - (ORD_W+1)'(LOG2_UNIT));
			end
			OP_SCAN: k_q <= k_q + ORD_W'(1);
			OP_ARD: begin
				u_q <= head_sel[UNIT_W-1:0];
				r_q <= raddr;
			end
			OP_BRD: r_q <= raddr;
			OP_MERGE: begin
				if (r_q < u_q)
					u_q <= r_q;
				k_q <= k_q + ORD_W'(1);
			end
			OP_SPLIT: begin
				k_q  <= split_k;
				pn_q <= head_sel;
				pu_q <= split_unit;
			end
			OP_PUSHA: begin
				pn_q <= head_sel;
				pu_q <= u_q;
			end
			OP_FCLR: k_q <= mt_rd.k;
			OP_OUT: begin
				m_stat_q <= cmd.status;
				m_addr_q <= ((cmd.status == ST_OK) && (cmd_q == CMD_ALLOC)) ?
				            {u_q, LOG2_UNIT'(HDR_BYTES)} : '0;
				m_used_q <= used_q;
				m_free_q <= eff - used_q;
			end
			default: ;
		endcase
	end

	// Stores
	balloc_ram #(.WIDTH(LINK_W), .DEPTH(UNITS)) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.raddr (raddr),
		.rdata (nx_rd)
	);

	balloc_ram #(.WIDTH(LINK_W), .DEPTH(UNITS)) u_prev_ram (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_waddr),
		.wdata (pv_wdata),
		.raddr (raddr),
		.rdata (pv_rd)
	);

	balloc_ram #(.WIDTH(META_W), .DEPTH(UNITS)) u_meta_ram (
		.clk   (clk),
		.we    (mt_we),
		.waddr (mt_waddr),
		.wdata (mt_wdata),
		.raddr (raddr),
		.rdata (mt_rdata)
	);

	// Status to the sequencer
	assign stat.cfg_wr     = cfg_wr;
	assign stat.clr_last   = (clr_cnt_q == '1);
	assign stat.is_free    = (cmd_q == CMD_FREE);
	assign stat.req_bad    = bad_q;
	assign stat.head_empty = (head_sel == NOLINK);
	assign stat.k_at_top   = (k_q == top_k);
	assign stat.k_at_need  = (k_q == need_q);
	assign stat.am_set     = mt_rd.am;
	assign stat.buddy_free = mt_rd.fs && (mt_rd.k == k_q);
	assign stat.out_free   = !m_tvalid_q || m_tready;

	// Result item
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - ADDR_W - 2*USED_W){1'b0}},
	                   m_free_q, m_used_q, m_addr_q};
	assign m_tuser  = m_stat_q;

endmodule

`default_nettype wire

>>> hw/rtl/buddy_allocator.sv
// Top level of the buddy allocator: sequencer plus datapath.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+----------------------------------------------
//  s_*      | in  | s_tvalid/s_tready | tdata size_bytes, address; tuser cmd
//  m_*      | out | m_tvalid/m_tready | tdata block_address, used, free; tuser status
//  apb      | in  | psel&penable      | heap_bytes at byte address 0
//
//  Allocation takes longer for each order split, a failed scan for each order scanned,
//  and a free for each buddy merged; a decode reject and a free of an unallocated block
//  touch no free list. The next item can be taken in the cycle the result turns valid.
//  After reset and after each heap_bytes write a sweep clears every unit of the stores;
//  no item is taken during it. The three unit stores share one read address.
//  The result register frees the engine while a result waits; it stalls only on a second.
`timescale 1ns / 1ps
`default_nettype none

module buddy_allocator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [15:0] size_bytes, [29:16] address, [31:30] zero
	input  wire logic [balloc_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] cmd
	input  wire logic [0:0]                        s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [13:0] block_address, [28:14] used_bytes, [43:29] free_bytes, [47:44] zero
	output logic      [balloc_pkg::OUT_DATA_W-1:0] m_tdata,
	// [1:0] status
	output logic      [balloc_pkg::STAT_W-1:0]     m_tuser,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [balloc_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [balloc_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [balloc_pkg::APB_DATA_W-1:0] prdata,
	output logic                                   pready
);

	import balloc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign pready = 1'b1;

	// Sequencer
	balloc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath
	balloc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser[0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata)
	);

endmodule

`default_nettype wire

>>> hw/rtl/balloc_chk.sv
// Port-level checks for the buddy allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module balloc_chk (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [balloc_pkg::OUT_DATA_W-1:0] m_tdata,
	input wire logic [balloc_pkg::STAT_W-1:0]     m_tuser
);

	import balloc_pkg::*;

	logic [ADDR_W-1:0] r_addr;
	logic [USED_W-1:0] r_used;
	logic [USED_W-1:0] r_free;

	assign r_addr = m_tdata[ADDR_W-1:0];
	assign r_used = m_tdata[ADDR_W+USED_W-1:ADDR_W];
	assign r_free = m_tdata[ADDR_W+2*USED_W-1:ADDR_W+USED_W];

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Report only known status codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_FAIL) || (m_tuser == ST_IGN))
		else $error("unknown status code");

	// Keep the accounting within the heap
	a_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, r_used} + {1'b0, r_free}) <= (USED_W+1)'(HEAP_BYTES))
		else $error("used plus free exceeds the heap");

	// Return an address only for a successful allocation, header past a unit start
	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (r_addr != '0) |->
			(m_tuser == ST_OK) && (r_addr[LOG2_UNIT-1:0] == LOG2_UNIT'(HDR_BYTES)) &&
			(r_used != '0))
		else $error("bad block address");

endmodule

bind buddy_allocator balloc_chk u_balloc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the buddy allocator: stream stimulus, APB set-up, scoreboard.
`timescale 1ns / 1ps

module tb;
	import balloc_pkg::*;

	localparam int NO_LINK   = 512;
	localparam int IDLE_LIMIT = 20000;

	// Expected content of one result item
	typedef struct {
		logic [13:0] block_address;
		res_status_t status;
		logic [14:0] used_bytes;
		logic [14:0] free_bytes;
	} heap_result_t;

	// Shadow heap: predicts every result and holds the results still due
	class heap_scoreboard;
		int          list_head [10];
		int          next_link [512];
		int          prev_link [512];
		bit          free_start [512];
		int          block_order [512];
		bit          alloc_mark [512];
		int          used_total;
		int          eff_size;
		int          top_order;
		bit          enabled;
		int          errors;
		int          live [$];
		heap_result_t pending [$];

		function void push_block(int u, int ord);
			int n;
			n = list_head[ord - LOG2_UNIT];
			next_link[u] = n;
			prev_link[u] = NO_LINK;
			if (n != NO_LINK)
				prev_link[n] = u;
			list_head[ord - LOG2_UNIT] = u;
			free_start[u] = 1;
			block_order[u] = ord;
		endfunction

		function void unlink_block(int u, int ord);
			int p;
			int n;
			p = prev_link[u];
			n = next_link[u];
			if (p != NO_LINK)
				next_link[p] = n;
			else
				list_head[ord - LOG2_UNIT] = n;
			if (n != NO_LINK)
				prev_link[n] = p;
			free_start[u] = 0;
		endfunction

		// Rebuild the heap for a new size
		function void set_heap(int heap);
			foreach (list_head[k])
				list_head[k] = NO_LINK;
			for (int i = 0; i < 512; i++) begin
				next_link[i] = 0;
				prev_link[i] = 0;
				free_start[i] = 0;
				block_order[i] = 0;
				alloc_mark[i] = 0;
			end
			used_total = 0;
			live.delete();
			eff_size = (heap > 16384) ? 16384 : heap;
			enabled = eff_size >= 32;
			top_order = LOG2_UNIT;
			if (!enabled) begin
				eff_size = 0;
			end else begin
				while (top_order < HEAP_ORDER && (2 << top_order) <= eff_size)
					top_order++;
				push_block(0, top_order);
			end
		endfunction

		function res_status_t do_alloc(int size, output int addr);
			int ord;
			int a;
			int u;
			addr = 0;
			if (!enabled || size == 0)
				return ST_FAIL;
			ord = LOG2_UNIT;
			while ((1 << ord) < size + 8)
				ord++;
			if (ord > top_order)
				return ST_FAIL;
			a = ord;
			while (a <= top_order && list_head[a - LOG2_UNIT] == NO_LINK)
				a++;
			if (a > top_order)
				return ST_FAIL;
			u = list_head[a - LOG2_UNIT];
			unlink_block(u, a);
			// split, keeping the lower half
			while (a > ord) begin
				a--;
				push_block(u, a);
				push_block(u + (1 << (a - LOG2_UNIT)), a);
				unlink_block(u, a);
			end
			block_order[u] = ord;
			alloc_mark[u] = 1;
			used_total += 1 << ord;
			if (used_total > eff_size)
				used_total = eff_size;
			addr = (u << LOG2_UNIT) + 8;
			live.push_back(addr);
			return ST_OK;
		endfunction

		function res_status_t do_free(int address);
			int off;
			int u;
			int ord;
			int b;
			if (!enabled || address < 8)
				return ST_IGN;
			off = address - 8;
			if ((off & 31) != 0)
				return ST_IGN;
			u = off >> LOG2_UNIT;
			if (u >= (1 << (top_order - LOG2_UNIT)) || !alloc_mark[u])
				return ST_IGN;
			alloc_mark[u] = 0;
			ord = block_order[u];
			if ((1 << ord) <= used_total)
				used_total -= 1 << ord;
			else
				used_total = 0;
			// merge with free buddies
			while (ord < top_order) begin
				b = u ^ (1 << (ord - LOG2_UNIT));
				if (!free_start[b] || block_order[b] != ord)
					break;
				unlink_block(b, ord);
				if (b < u)
					u = b;
				ord++;
			end
			push_block(u, ord);
			foreach (live[i])
				if (live[i] == address) begin
					live.delete(i);
					break;
				end
			return ST_OK;
		endfunction

		// Note an accepted input item
		function void note_item(bit cmd, int size, int address);
			heap_result_t r;
			int addr;
			if (cmd == CMD_ALLOC)
				r.status = do_alloc(size, addr);
			else begin
				r.status = do_free(address);
				addr = 0;
			end
			r.block_address = addr[13:0];
			r.used_bytes = used_total[14:0];
			r.free_bytes = 15'(eff_size - used_total);
			pending.push_back(r);
		endfunction

		// Compare a result item with the oldest expectation
		function void check_result(logic [47:0] data, logic [1:0] stat);
			heap_result_t r;
			if (pending.size() == 0) begin
				$error("unexpected result item: tdata %h status %0d", data, stat);
				errors++;
				return;
			end
			r = pending.pop_front();
			if (data[13:0] !== r.block_address) begin
				$error("block_address: expected %0d, got %0d", r.block_address, data[13:0]);
				errors++;
			end
			if (stat !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, stat);
				errors++;
			end
			if (data[28:14] !== r.used_bytes) begin
				$error("used_bytes: expected %0d, got %0d", r.used_bytes, data[28:14]);
				errors++;
			end
			if (data[43:29] !== r.free_bytes) begin
				$error("free_bytes: expected %0d, got %0d", r.free_bytes, data[43:29]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	heap_scoreboard heap_sb;
	bit             no_stall;
	int             rx_wait;
	int             idle_cycles;

	buddy_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Check each accepted result item and draw the next receiver stall
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) begin
			heap_sb.check_result(m_tdata, m_tuser);
			rx_wait = no_stall ? 0 : $urandom_range(0, 5);
		end

	// Drive the receiver side
	always @(negedge clk) begin
		m_tready <= (rx_wait == 0);
		if (rx_wait > 0)
			rx_wait--;
	end

	// Stop the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("buddy_allocator verification failed");
			$finish;
		end
	end

	// Send one item; entered and left at a falling edge
	task automatic send_item(bit cmd, int size, int address);
		int gap;
		gap = no_stall ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {2'b00, address[13:0], size[15:0]};
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
			@(negedge clk);
		end
		heap_sb.note_item(cmd, size, address);
		@(negedge clk);
	endtask

	// Hold off until every result has arrived
	task automatic drain();
		s_tvalid <= 1'b0;
		while (heap_sb.pending.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// Write heap_bytes while the block is idle
	task automatic write_heap(int heap);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_HEAP_BYTES, 2'b00};
		pwdata  <= heap;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		heap_sb.set_heap(heap & 32'h7fff);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Extremes, both operations and the bad cases
	task automatic directed_items();
		int a;
		send_item(CMD_ALLOC, 0, 0);
		send_item(CMD_ALLOC, 65535, 16383);
		send_item(CMD_ALLOC, 16377, 0);
		send_item(CMD_ALLOC, 16376, 0);
		send_item(CMD_FREE, 0, 8);
		send_item(CMD_ALLOC, 1, 0);
		send_item(CMD_ALLOC, 24, 0);
		send_item(CMD_ALLOC, 25, 0);
		send_item(CMD_ALLOC, 8000, 0);
		send_item(CMD_FREE, 65535, 0);
		send_item(CMD_FREE, 0, 7);
		send_item(CMD_FREE, 0, 9);
		send_item(CMD_FREE, 0, 16383);
		send_item(CMD_FREE, 0, 16360);
		send_item(CMD_FREE, 0, 72);
		a = heap_sb.live[0];
		send_item(CMD_FREE, 0, a);
		send_item(CMD_FREE, 0, a);
		while (heap_sb.live.size() > 0)
			send_item(CMD_FREE, 0, heap_sb.live[0]);
	endtask

	// Mostly well-formed alloc/free traffic with some noise
	task automatic random_items(int count);
		int r;
		int sel;
		int size;
		int address;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0)
				no_stall = ($urandom_range(0, 3) == 0);
			if (i == count / 2)
				drain();
			r = $urandom_range(0, 99);
			sel = $urandom_range(0, 99);
			address = $urandom_range(0, 16383);
			size = $urandom_range(0, 65535);
			if (r < 45) begin
				if (sel < 70)
					size = $urandom_range(1, 120);
				else if (sel < 90)
					size = $urandom_range(121, 2040);
				else if (sel < 97)
					size = $urandom_range(2041, 16376);
				send_item(CMD_ALLOC, size, address);
			end else if (r < 85 && heap_sb.live.size() > 0) begin
				address = heap_sb.live[$urandom_range(0, heap_sb.live.size() - 1)];
				send_item(CMD_FREE, size, address);
			end else begin
				if (sel < 30 && heap_sb.live.size() > 0)
					address = (heap_sb.live[0] + $urandom_range(1, 40)) & 16383;
				else if (sel < 40)
					size = 0;
				send_item(sel[0], size, address);
			end
		end
	endtask

	initial begin
		heap_sb  = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		no_stall = 1'b0;
		rx_wait  = 0;
		idle_cycles = 0;
		heap_sb.set_heap(16384);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		directed_items();
		random_items(450);
		write_heap(0);
		random_items(30);
		write_heap(31);
		random_items(30);
		write_heap(32);
		random_items(60);
		write_heap(100);
		random_items(120);
		write_heap(1000);
		random_items(200);
		write_heap(32767);
		random_items(300);
		write_heap(16383);
		random_items(250);
		write_heap($urandom_range(33, 20000));
		random_items(150);
		drain();
		if (heap_sb.errors == 0 && heap_sb.pending.size() == 0)
			$display("buddy_allocator verification clean");
		else
			$display("buddy_allocator verification failed");
		$finish;
	end
endmodule
